FILE: src/irc_pkg.sv
// Shared types, codes and scaling constants for the IMU raw sample unit converter.
// No dependencies; every other file but irc_intf imports this package.
package irc_pkg;

  typedef enum logic [1:0] {
    CMD_ACCEL = 2'd0,
    CMD_GYRO  = 2'd1,
    CMD_TEMP  = 2'd2,
    CMD_MAG   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_ADJ_X = 2'd0,
    REG_ADJ_Y = 2'd1,
    REG_ADJ_Z = 2'd2
  } reg_idx_t;

  typedef logic [8:0] adj_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctrl_t;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam adj_t ADJ_RESET = 9'd256;

  localparam logic [7:0] MAG_RDY_MASK = 8'h01;
  localparam logic [7:0] MAG_OVF_MASK = 8'h08;

  // Lane datapath widths.
  localparam int unsigned M1_W   = 25;
  localparam int unsigned T_W    = 27;
  localparam int unsigned RCP_W  = 30;
  localparam int unsigned PROD_W = 57;
  localparam int unsigned Q_W    = 18;
  localparam int unsigned VAL_W  = 20;

  // Accel: raw * 1000 / 8192 = raw * 125 / 1024.
  localparam int unsigned ACC_NUM   = 125;
  localparam int unsigned ACC_SHIFT = 10;

  // Magnetometer: raw * adj * 49120 / (256 * 32760) = raw * adj * 307 / (64 * 819).
  localparam int unsigned MAG_NUM       = 307;
  localparam int unsigned MAG_PRE_SHIFT = 6;
  localparam int unsigned MAG_DIV       = 819;

  localparam int unsigned GYR_MUL = 100;
  localparam int unsigned GYR_DIV = 655;
  localparam int unsigned TMP_MUL = 10000;
  localparam int unsigned TMP_DIV = 33387;

  localparam int unsigned GYR_SHIFT = 25;
  localparam int unsigned TMP_SHIFT = 31;
  localparam int unsigned MAG_SHIFT = 36;

  // Rounded-up reciprocals; the shifts are large enough for exact quotients.
  localparam logic [RCP_W-1:0] GYR_RCP =
    RCP_W'(((64'd1 << GYR_SHIFT) * GYR_MUL + GYR_DIV - 1) / GYR_DIV);
  localparam logic [RCP_W-1:0] TMP_RCP =
    RCP_W'(((64'd1 << TMP_SHIFT) * TMP_MUL + TMP_DIV - 1) / TMP_DIV);
  localparam logic [RCP_W-1:0] MAG_RCP =
    RCP_W'(((64'd1 << MAG_SHIFT) + MAG_DIV - 1) / MAG_DIV);

  localparam logic signed [VAL_W-1:0] TMP_OFS = 20'sd2100;

endpackage

FILE: src/irc_intf.sv
// Handshake channel interfaces for raw sample items and converted result items.
// Depends on irc_pkg for nothing but shares its house style.
interface irc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_0;
  logic [7:0] byte_1;
  logic [7:0] byte_2;
  logic [7:0] byte_3;
  logic [7:0] byte_4;
  logic [7:0] byte_5;
  logic [7:0] mag_status_one;
  logic [7:0] mag_status_two;

  modport source (
    output valid, command, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
           mag_status_one, mag_status_two,
    input  ready
  );
  modport sink (
    input  valid, command, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
           mag_status_one, mag_status_two,
    output ready
  );
endinterface

interface irc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic signed [15:0] z_value;
  logic        [1:0]  status;

  modport source (
    output valid, x_value, y_value, z_value, status,
    input  ready
  );
  modport sink (
    input  valid, x_value, y_value, z_value, status,
    output ready
  );
endinterface

FILE: src/imu_raw_sample_unit_converter.sv
// IMU raw sample unit converter: three axis lanes, a merging stage and an APB register file.
// Throughput is one item per cycle, set by the three-stage lane multiplier pipeline
// followed by the output register; a stalled output holds the pipeline behind it.
// Reset (rst_n low, synchronous) empties the pipeline and sets each adjustment to 256.
// Depends on irc_pkg, irc_intf, irc_cfg_regs, irc_lane and irc_merge.
module imu_raw_sample_unit_converter
  import irc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  irc_in_if.sink            in_chan,
  irc_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  adj_t       adj_x, adj_y, adj_z;
  pipe_ctrl_t ctrl;
  logic       v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, vo_r, vo_nxt;
  logic       go_out, adv3, free3, adv2, free2, adv1, free1, accept;
  cmd_t       cmd_in;
  status_t    st_in;
  cmd_t       cmd1_r, cmd2_r, cmd3_r;
  status_t    st1_r, st2_r, st3_r;
  logic [NUM_LANES-1:0][Q_W-1:0] quot;
  logic [NUM_LANES-1:0]          neg;

  irc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .adj_x   (adj_x),
    .adj_y   (adj_y),
    .adj_z   (adj_z)
  );

  assign go_out = !vo_r || out_chan.ready;
  assign adv3   = v3_r && go_out;
  assign free3  = !v3_r || go_out;
  assign adv2   = v2_r && free3;
  assign free2  = !v2_r || free3;
  assign adv1   = v1_r && free2;
  assign free1  = !v1_r || free2;
  assign accept = in_chan.valid && free1;

  assign in_chan.ready = free1;

  assign ctrl.ld1 = accept;
  assign ctrl.ld2 = adv1;
  assign ctrl.ld3 = adv2;

  assign cmd_in = cmd_t'(in_chan.command);

  always_comb begin
    st_in = ST_VALID;
    if (cmd_in == CMD_MAG) begin
      if ((in_chan.mag_status_one & MAG_RDY_MASK) == 8'd0) begin
        st_in = ST_NOT_READY;
      end else if ((in_chan.mag_status_two & MAG_OVF_MASK) != 8'd0) begin
        st_in = ST_OVERFLOW;
      end
    end
  end

  irc_lane u_lane_x (
    .clk    (clk),
    .ctrl   (ctrl),
    .cmd    (cmd_in),
    .byte_a (in_chan.byte_0),
    .byte_b (in_chan.byte_1),
    .adj    (adj_x),
    .quot   (quot[0]),
    .neg    (neg[0])
  );

  irc_lane u_lane_y (
    .clk    (clk),
    .ctrl   (ctrl),
    .cmd    (cmd_in),
    .byte_a (in_chan.byte_2),
    .byte_b (in_chan.byte_3),
    .adj    (adj_y),
    .quot   (quot[1]),
    .neg    (neg[1])
  );

  irc_lane u_lane_z (
    .clk    (clk),
    .ctrl   (ctrl),
    .cmd    (cmd_in),
    .byte_a (in_chan.byte_4),
    .byte_b (in_chan.byte_5),
    .adj    (adj_z),
    .quot   (quot[2]),
    .neg    (neg[2])
  );

  irc_merge u_merge (
    .clk        (clk),
    .load       (adv3),
    .cmd        (cmd3_r),
    .status     (st3_r),
    .quot       (quot),
    .neg        (neg),
    .x_value    (out_chan.x_value),
    .y_value    (out_chan.y_value),
    .z_value    (out_chan.z_value),
    .status_out (out_chan.status)
  );

  always_comb begin
    v1_nxt = accept ? 1'b1 : (adv1 ? 1'b0 : v1_r);
    v2_nxt = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_r);
    v3_nxt = adv2 ? 1'b1 : (adv3 ? 1'b0 : v3_r);
    vo_nxt = adv3 ? 1'b1 : ((vo_r && out_chan.ready) ? 1'b0 : vo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd1_r <= cmd_in;
      st1_r  <= st_in;
    end
    if (adv1) begin
      cmd2_r <= cmd1_r;
      st2_r  <= st1_r;
    end
    if (adv2) begin
      cmd3_r <= cmd2_r;
      st3_r  <= st2_r;
    end
  end

  assign out_chan.valid = vo_r;

endmodule

FILE: src/irc_cfg_regs.sv
// APB-style register file holding the three magnetometer adjustment factors.
// Depends on irc_pkg.
module irc_cfg_regs
  import irc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output adj_t              adj_x,
  output adj_t              adj_y,
  output adj_t              adj_z
);

  adj_t adj_x_r, adj_x_nxt;
  adj_t adj_y_r, adj_y_nxt;
  adj_t adj_z_r, adj_z_nxt;
  logic wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    adj_x_nxt = adj_x_r;
    adj_y_nxt = adj_y_r;
    adj_z_nxt = adj_z_r;
    if (wr_en) begin
      case (idx)
        REG_ADJ_X: adj_x_nxt = pwdata[8:0];
        REG_ADJ_Y: adj_y_nxt = pwdata[8:0];
        REG_ADJ_Z: adj_z_nxt = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ADJ_X: prdata = DATA_W'(adj_x_r);
      REG_ADJ_Y: prdata = DATA_W'(adj_y_r);
      REG_ADJ_Z: prdata = DATA_W'(adj_z_r);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_x_r <= ADJ_RESET;
      adj_y_r <= ADJ_RESET;
      adj_z_r <= ADJ_RESET;
    end else begin
      adj_x_r <= adj_x_nxt;
      adj_y_r <= adj_y_nxt;
      adj_z_r <= adj_z_nxt;
    end
  end

  assign adj_x = adj_x_r;
  assign adj_y = adj_y_r;
  assign adj_z = adj_z_r;

endmodule

FILE: src/irc_lane.sv
// One axis lane: word assembly, magnitude scaling and reciprocal division in three stages.
// Depends on irc_pkg; three copies run side by side in the top level.
module irc_lane
  import irc_pkg::*;
(
  input  logic           clk,
  input  pipe_ctrl_t     ctrl,
  input  cmd_t           cmd,
  input  logic [7:0]     byte_a,
  input  logic [7:0]     byte_b,
  input  adj_t           adj,
  output logic [Q_W-1:0] quot,
  output logic           neg
);

  logic [15:0]       word;
  logic [15:0]       abs_w;
  adj_t              fac;
  logic [M1_W-1:0]   m1_r, m1_nxt;
  cmd_t              cmd1_r, cmd2_r;
  logic              neg1_r, neg2_r, neg3_r;
  logic [33:0]       acc_prod;
  logic [33:0]       mag_prod;
  logic [T_W-1:0]    t_r, t_nxt;
  logic [RCP_W-1:0]  rcp;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q_r, q_nxt;

  assign word  = (cmd == CMD_MAG) ? {byte_b, byte_a} : {byte_a, byte_b};
  assign abs_w = word[15] ? 16'(-word) : word;
  assign fac   = (cmd == CMD_MAG) ? adj : 9'd1;
  assign m1_nxt = M1_W'(abs_w) * M1_W'(fac);

  assign acc_prod = 34'(m1_r) * 34'(ACC_NUM);
  assign mag_prod = 34'(m1_r) * 34'(MAG_NUM);

  always_comb begin
    case (cmd1_r)
      CMD_ACCEL: t_nxt = T_W'(acc_prod >> ACC_SHIFT);
      CMD_MAG:   t_nxt = T_W'(mag_prod >> MAG_PRE_SHIFT);
      default:   t_nxt = T_W'(m1_r);
    endcase
  end

  always_comb begin
    case (cmd2_r)
      CMD_GYRO: rcp = GYR_RCP;
      CMD_TEMP: rcp = TMP_RCP;
      CMD_MAG:  rcp = MAG_RCP;
      default:  rcp = RCP_W'(1);
    endcase
  end

  assign prod = PROD_W'(t_r) * PROD_W'(rcp);

  always_comb begin
    case (cmd2_r)
      CMD_GYRO: q_nxt = Q_W'(prod >> GYR_SHIFT);
      CMD_TEMP: q_nxt = Q_W'(prod >> TMP_SHIFT);
      CMD_MAG:  q_nxt = Q_W'(prod >> MAG_SHIFT);
      default:  q_nxt = Q_W'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      m1_r   <= m1_nxt;
      cmd1_r <= cmd;
      neg1_r <= word[15];
    end
    if (ctrl.ld2) begin
      t_r    <= t_nxt;
      cmd2_r <= cmd1_r;
      neg2_r <= neg1_r;
    end
    if (ctrl.ld3) begin
      q_r    <= q_nxt;
      neg3_r <= neg2_r;
    end
  end

  assign quot = q_r;
  assign neg  = neg3_r;

endmodule

FILE: src/irc_merge.sv
// Merging stage: restores signs, applies the temperature offset, saturates and masks by status.
// Zeroes y and z for temperature. Depends on irc_pkg; holds the top level's output register.
module irc_merge
  import irc_pkg::*;
(
  input  logic                          clk,
  input  logic                          load,
  input  cmd_t                          cmd,
  input  status_t                       status,
  input  logic [NUM_LANES-1:0][Q_W-1:0] quot,
  input  logic [NUM_LANES-1:0]          neg,
  output logic signed [15:0]            x_value,
  output logic signed [15:0]            y_value,
  output logic signed [15:0]            z_value,
  output logic [1:0]                    status_out
);

  function automatic logic signed [15:0] sat16(input logic signed [VAL_W-1:0] v);
    logic signed [15:0] res;
    if (v > VAL_W'(32767)) begin
      res = 16'sh7FFF;
    end else if (v < -VAL_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  logic signed [VAL_W-1:0] val [NUM_LANES];
  logic signed [15:0]      res_nxt [NUM_LANES];
  logic signed [15:0]      x_r, y_r, z_r;
  logic [1:0]              st_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      val[i] = neg[i] ? -$signed(VAL_W'(quot[i])) : $signed(VAL_W'(quot[i]));
      if (i == 0 && cmd == CMD_TEMP) begin
        val[i] = val[i] + TMP_OFS;
      end
      if (status != ST_VALID || (i != 0 && cmd == CMD_TEMP)) begin
        res_nxt[i] = '0;
      end else begin
        res_nxt[i] = sat16(val[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r  <= res_nxt[0];
      y_r  <= res_nxt[1];
      z_r  <= res_nxt[2];
      st_r <= status;
    end
  end

  assign x_value    = x_r;
  assign y_value    = y_r;
  assign z_value    = z_r;
  assign status_out = st_r;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for imu_raw_sample_unit_converter: directed and random raw bursts,
// register writes over the APB-style port, and a scaling predictor checked item by item.
// Depends on irc_pkg, irc_intf and the converter RTL.
`timescale 1ns / 100ps

module tb;
  import irc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned UNMAPPED_IDX = NUM_LANES;
  localparam int unsigned ITEMS_PER_PHASE = 640;

  localparam longint MG_PER_G           = 1000;
  localparam longint ACCEL_COUNTS_PER_G = 8192;
  localparam longint GYRO_SCALE_MUL     = 100;
  localparam longint GYRO_LSB_DIV       = 655;
  localparam longint TEMP_SCALE_MUL     = 10000;
  localparam longint TEMP_SCALE_DIV     = 33387;
  localparam longint TEMP_OFFSET        = 2100;
  localparam longint MAG_FULL_SCALE     = 49120;
  localparam longint MAG_SCALE_DIV      = 256 * 32760;

  typedef struct packed {
    cmd_t            command;
    logic [5:0][7:0] burst;
    logic [7:0]      status_one;
    logic [7:0]      status_two;
  } raw_item_t;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic signed [15:0] z_value;
    status_t            status;
  } conv_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  irc_in_if  in_if ();
  irc_out_if out_if ();

  imu_raw_sample_unit_converter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  adj_t         mag_adj [NUM_LANES];
  conv_result_t pending_results [$];
  conv_result_t want;
  int           err_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_idle_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.x_value !== want.x_value) begin
          $error("x_value: expected %0d, got %0d", $signed(want.x_value),
                 $signed(out_if.x_value));
          err_count++;
        end
        if (out_if.y_value !== want.y_value) begin
          $error("y_value: expected %0d, got %0d", $signed(want.y_value),
                 $signed(out_if.y_value));
          err_count++;
        end
        if (out_if.z_value !== want.z_value) begin
          $error("z_value: expected %0d, got %0d", $signed(want.z_value),
                 $signed(out_if.z_value));
          err_count++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          err_count++;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic conv_result_t convert_sample(input raw_item_t it);
    conv_result_t res;
    longint       w [3];
    longint       v [3];
    for (int i = 0; i < 3; i++) begin
      v[i] = 0;
      if (it.command == CMD_MAG)
        w[i] = $signed({it.burst[2*i+1], it.burst[2*i]});
      else
        w[i] = $signed({it.burst[2*i], it.burst[2*i+1]});
    end
    res.status = ST_VALID;
    case (it.command)
      CMD_ACCEL: begin
        for (int i = 0; i < 3; i++) v[i] = w[i] * MG_PER_G / ACCEL_COUNTS_PER_G;
      end
      CMD_GYRO: begin
        for (int i = 0; i < 3; i++) v[i] = w[i] * GYRO_SCALE_MUL / GYRO_LSB_DIV;
      end
      CMD_TEMP: begin
        v[0] = w[0] * TEMP_SCALE_MUL / TEMP_SCALE_DIV + TEMP_OFFSET;
      end
      default: begin
        if ((it.status_one & MAG_RDY_MASK) == 8'd0) begin
          res.status = ST_NOT_READY;
        end else if ((it.status_two & MAG_OVF_MASK) != 8'd0) begin
          res.status = ST_OVERFLOW;
        end else begin
          for (int i = 0; i < 3; i++)
            v[i] = w[i] * longint'(mag_adj[i]) * MAG_FULL_SCALE / MAG_SCALE_DIV;
        end
      end
    endcase
    res.x_value = clamp16(v[0]);
    res.y_value = clamp16(v[1]);
    res.z_value = clamp16(v[2]);
    return res;
  endfunction

  function automatic raw_item_t make_item(input cmd_t cmd, input logic [15:0] w0,
                                          input logic [15:0] w1, input logic [15:0] w2,
                                          input logic [7:0] st1, input logic [7:0] st2);
    raw_item_t   it;
    logic [15:0] w [3];
    w[0] = w0;
    w[1] = w1;
    w[2] = w2;
    it.command = cmd;
    for (int i = 0; i < 3; i++) begin
      if (cmd == CMD_MAG) begin
        it.burst[2*i]   = w[i][7:0];
        it.burst[2*i+1] = w[i][15:8];
      end else begin
        it.burst[2*i]   = w[i][15:8];
        it.burst[2*i+1] = w[i][7:0];
      end
    end
    it.status_one = st1;
    it.status_two = st2;
    return it;
  endfunction

  function automatic logic [7:0] random_byte();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       return 8'h00;
        1:       return 8'hFF;
        2:       return 8'h7F;
        default: return 8'h80;
      endcase
    end
    return 8'($urandom);
  endfunction

  function automatic raw_item_t random_item();
    raw_item_t it;
    it.command = cmd_t'($urandom_range(3));
    for (int i = 0; i < 6; i++) it.burst[i] = random_byte();
    it.status_one = 8'($urandom);
    it.status_two = 8'($urandom);
    if ($urandom_range(99) < 85) it.status_one = it.status_one | MAG_RDY_MASK;
    else it.status_one = it.status_one & ~MAG_RDY_MASK;
    if ($urandom_range(99) < 85) it.status_two = it.status_two & ~MAG_OVF_MASK;
    else it.status_two = it.status_two | MAG_OVF_MASK;
    return it;
  endfunction

  task automatic send_item(input raw_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.command        <= it.command;
    in_if.byte_0         <= it.burst[0];
    in_if.byte_1         <= it.burst[1];
    in_if.byte_2         <= it.burst[2];
    in_if.byte_3         <= it.burst[3];
    in_if.byte_4         <= it.burst[4];
    in_if.byte_5         <= it.burst[5];
    in_if.mag_status_one <= it.status_one;
    in_if.mag_status_two <= it.status_two;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(convert_sample(it));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NUM_LANES) mag_adj[idx] = data[8:0];
    @(posedge clk);
  endtask

  task automatic set_adjust(input adj_t ax, input adj_t ay, input adj_t az);
    write_reg(REG_ADJ_X, {23'($urandom), ax});
    write_reg(REG_ADJ_Y, {23'($urandom), ay});
    write_reg(REG_ADJ_Z, {23'($urandom), az});
  endtask

  task automatic test_accel_gyro_extremes();
    send_item(make_item(CMD_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, 8'h00, 8'h00));
    send_item(make_item(CMD_ACCEL, 16'hFFFF, 16'h0001, 16'hFFF7, 8'h00, 8'hFF));
    send_item(make_item(CMD_GYRO, 16'h7FFF, 16'h8000, 16'h0000, 8'hFF, 8'h00));
    send_item(make_item(CMD_GYRO, 16'hFFFF, 16'hFD71, 16'h028F, 8'hFE, 8'hF7));
  endtask

  task automatic test_temperature();
    send_item(make_item(CMD_TEMP, 16'h7FFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    send_item(make_item(CMD_TEMP, 16'h8000, 16'h1234, 16'h8000, 8'h00, 8'h08));
    send_item(make_item(CMD_TEMP, 16'h0000, 16'h7FFF, 16'h5A5A, 8'h01, 8'h00));
  endtask

  task automatic test_mag_status();
    send_item(make_item(CMD_MAG, 16'h7FFF, 16'h8000, 16'h0001, 8'h01, 8'h00));
    send_item(make_item(CMD_MAG, 16'hFFFF, 16'h0000, 16'h1234, 8'hFF, 8'hF7));
    send_item(make_item(CMD_MAG, 16'h1111, 16'h2222, 16'h3333, 8'hFE, 8'hFF));
    send_item(make_item(CMD_MAG, 16'h1111, 16'h2222, 16'h3333, 8'h01, 8'h08));
  endtask

  task automatic test_mag_adjust_settings();
    wait_drained();
    set_adjust(9'd128, 9'd128, 9'd128);
    send_item(make_item(CMD_MAG, 16'h7FFF, 16'h8000, 16'hFF00, 8'h01, 8'h00));
    send_item(make_item(CMD_MAG, 16'h0ABC, 16'hF543, 16'h0001, 8'h01, 8'h00));
    wait_drained();
    set_adjust(9'd383, 9'd383, 9'd383);
    send_item(make_item(CMD_MAG, 16'h7FFF, 16'h8000, 16'h3A00, 8'h01, 8'h00));
    send_item(make_item(CMD_MAG, 16'hFFFF, 16'h0001, 16'hC600, 8'h01, 8'h00));
    wait_drained();
    set_adjust(9'd511, 9'd0, 9'd1);
    write_reg(UNMAPPED_IDX, 32'hFFFF_FFFF);
    send_item(make_item(CMD_MAG, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h01, 8'h00));
    send_item(make_item(CMD_MAG, 16'h8000, 16'h8000, 16'h8000, 8'h01, 8'h00));
    send_item(make_item(CMD_MAG, 16'h2000, 16'hE000, 16'hFFFF, 8'h01, 8'h00));
    wait_drained();
    set_adjust(9'($urandom_range(128, 383)), 9'($urandom_range(128, 383)),
               9'($urandom_range(128, 383)));
    send_item(make_item(CMD_MAG, 16'h4000, 16'hC000, 16'h0100, 8'h01, 8'h00));
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned src_pct,
                                     input int unsigned snk_pct, input bit pause_midway);
    wait_drained();
    set_adjust(9'($urandom_range(128, 383)), 9'($urandom_range(128, 383)),
               9'($urandom_range(128, 383)));
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) wait_drained();
      send_item(random_item());
    end
  endtask

  initial begin
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_if.valid          <= 1'b0;
    in_if.command        <= CMD_ACCEL;
    in_if.byte_0         <= 8'h00;
    in_if.byte_1         <= 8'h00;
    in_if.byte_2         <= 8'h00;
    in_if.byte_3         <= 8'h00;
    in_if.byte_4         <= 8'h00;
    in_if.byte_5         <= 8'h00;
    in_if.mag_status_one <= 8'h00;
    in_if.mag_status_two <= 8'h00;
    rst_n                <= 1'b0;
    for (int i = 0; i < NUM_LANES; i++) mag_adj[i] = ADJ_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_accel_gyro_extremes();
    test_temperature();
    test_mag_status();
    test_mag_adjust_settings();
    test_random_traffic(ITEMS_PER_PHASE, 32, 76, 1'b1);
    test_random_traffic(ITEMS_PER_PHASE, 76, 32, 1'b0);
    test_random_traffic(ITEMS_PER_PHASE, 0, 0, 1'b0);
    wait_drained();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
